// ----- rtl/bcg_pkg.sv -----
// ----------------------------------------------------------------------------
// bcg_pkg: shared types and constants for the button gesture detector
// Holds the one-hot gesture state type, the register index codes, the delay
// bundle and the per-sample step result that travels between modules.
// ----------------------------------------------------------------------------
package bcg_pkg;

  typedef enum logic [9:0] {
    ST_IDLE         = 10'b00_0000_0001,
    ST_DEBOUNCE     = 10'b00_0000_0010,
    ST_PRESSED      = 10'b00_0000_0100,
    ST_CLICK_UP     = 10'b00_0000_1000,
    ST_CLICK_IDLE   = 10'b00_0001_0000,
    ST_SINGLE       = 10'b00_0010_0000,
    ST_DBL_DEBOUNCE = 10'b00_0100_0000,
    ST_DOUBLE       = 10'b00_1000_0000,
    ST_LONG         = 10'b01_0000_0000,
    ST_OTHER_UP     = 10'b10_0000_0000
  } gesture_state_t;

  // Encoded state values as seen on the result port.
  localparam logic [3:0] CODE_IDLE         = 4'd0;
  localparam logic [3:0] CODE_DEBOUNCE     = 4'd1;
  localparam logic [3:0] CODE_PRESSED      = 4'd2;
  localparam logic [3:0] CODE_CLICK_UP     = 4'd3;
  localparam logic [3:0] CODE_CLICK_IDLE   = 4'd4;
  localparam logic [3:0] CODE_SINGLE       = 4'd5;
  localparam logic [3:0] CODE_DBL_DEBOUNCE = 4'd6;
  localparam logic [3:0] CODE_DOUBLE       = 4'd7;
  localparam logic [3:0] CODE_LONG         = 4'd8;
  localparam logic [3:0] CODE_OTHER_UP     = 4'd9;

  // Configuration register indexes.
  localparam logic [1:0] REG_SETTLE_DELAY       = 2'd0;
  localparam logic [1:0] REG_LONG_CLICK_DELAY   = 2'd1;
  localparam logic [1:0] REG_SINGLE_CLICK_DELAY = 2'd2;

  localparam logic [23:0] SETTLE_DELAY_RST       = 24'd20000;
  localparam logic [23:0] LONG_CLICK_DELAY_RST   = 24'd800000;
  localparam logic [23:0] SINGLE_CLICK_DELAY_RST = 24'd300000;

  typedef struct packed {
    logic [23:0] settle_delay;
    logic [23:0] long_click_delay;
    logic [23:0] single_click_delay;
  } delays_t;

  typedef struct packed {
    gesture_state_t state;
    logic           changed;
    logic           click;
    logic           single_click;
    logic           double_click;
    logic           long_click;
    logic           released;
  } step_t;

  function automatic logic [3:0] state_code(input gesture_state_t s);
    logic [3:0] code;
    unique case (s)
      ST_IDLE:         code = CODE_IDLE;
      ST_DEBOUNCE:     code = CODE_DEBOUNCE;
      ST_PRESSED:      code = CODE_PRESSED;
      ST_CLICK_UP:     code = CODE_CLICK_UP;
      ST_CLICK_IDLE:   code = CODE_CLICK_IDLE;
      ST_SINGLE:       code = CODE_SINGLE;
      ST_DBL_DEBOUNCE: code = CODE_DBL_DEBOUNCE;
      ST_DOUBLE:       code = CODE_DOUBLE;
      ST_LONG:         code = CODE_LONG;
      ST_OTHER_UP:     code = CODE_OTHER_UP;
      default:         code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/button_click_gesture_detector.sv -----
// ----------------------------------------------------------------------------
// button_click_gesture_detector: debounce and click gesture recognition
// An accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle unless the result channel stalls; the state
//   loop is one 32-bit subtract, three compares and the next-state table.
// Reset (rst_n, synchronous, active low): state idle, last change time zero,
//   delays at 20000, 800000 and 300000 us, pipeline empty.
// ----------------------------------------------------------------------------
module button_click_gesture_detector
  import bcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel: one button sample with its timestamp per beat.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_pressed,
  input  logic [31:0] in_time_us,
  // Result channel: state and event flags after each sample.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_gesture_state,
  output logic        out_changed,
  output logic        out_click,
  output logic        out_single_click,
  output logic        out_double_click,
  output logic        out_long_click,
  output logic        out_released,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  // The design is two register stages. The input register captures a sample
  // beat. When the result register is free (empty, or being drained in this
  // cycle), the captured sample is run through the gesture logic: the state
  // and last change time update and the result register loads, all at once.
  // Because the state loop closes in that same update, a new sample can
  // follow every cycle while the result register is free.

  delays_t        delays;
  step_t          step;

  logic           s1_valid_r;
  logic           s1_pressed_r;
  logic [31:0]    s1_time_r;

  gesture_state_t state_r;
  gesture_state_t state_nxt;
  logic [31:0]    last_time_r;
  logic [31:0]    last_time_nxt;

  logic           out_valid_r;
  step_t          out_step_r;

  logic           advance;
  logic           process;

  bcg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .delays    (delays)
  );

  bcg_fsm u_fsm (
    .cur_state (state_r),
    .last_time (last_time_r),
    .pressed   (s1_pressed_r),
    .time_us   (s1_time_r),
    .delays    (delays),
    .step      (step)
  );

  // The result register can take a new beat when it is empty or its beat
  // leaves this cycle; the input register then frees up as well.
  assign advance  = !out_valid_r || out_ready;
  assign process  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  // The change time is recorded only on a real state change, so an idle
  // machine with the button up keeps its old time stamp.
  always_comb begin
    state_nxt     = state_r;
    last_time_nxt = last_time_r;
    if (process && step.changed) begin
      state_nxt     = step.state;
      last_time_nxt = s1_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ST_IDLE;
      last_time_r <= 32'd0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      state_r     <= state_nxt;
      last_time_r <= last_time_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pressed_r <= in_pressed;
      s1_time_r    <= in_time_us;
    end
    if (process) begin
      out_step_r <= step;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_gesture_state = state_code(out_step_r.state);
  assign out_changed       = out_step_r.changed;
  assign out_click         = out_step_r.click;
  assign out_single_click  = out_step_r.single_click;
  assign out_double_click  = out_step_r.double_click;
  assign out_long_click    = out_step_r.long_click;
  assign out_released      = out_step_r.released;

endmodule

// ----- rtl/bcg_cfg.sv -----
// ----------------------------------------------------------------------------
// bcg_cfg: delay configuration registers
// Decodes writes on the configuration port into the three delay registers.
// ----------------------------------------------------------------------------
module bcg_cfg
  import bcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output delays_t     delays
);

  delays_t delays_r;
  delays_t delays_nxt;

  always_comb begin
    delays_nxt = delays_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SETTLE_DELAY:       delays_nxt.settle_delay       = cfg_wdata;
        REG_LONG_CLICK_DELAY:   delays_nxt.long_click_delay   = cfg_wdata;
        REG_SINGLE_CLICK_DELAY: delays_nxt.single_click_delay = cfg_wdata;
        default:                delays_nxt = delays_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delays_r.settle_delay       <= SETTLE_DELAY_RST;
      delays_r.long_click_delay   <= LONG_CLICK_DELAY_RST;
      delays_r.single_click_delay <= SINGLE_CLICK_DELAY_RST;
    end else begin
      delays_r <= delays_nxt;
    end
  end

  assign delays = delays_r;

endmodule

// ----- rtl/bcg_fsm.sv -----
// ----------------------------------------------------------------------------
// bcg_fsm: gesture next-state and event logic
// Computes elapsed time since the last change, compares it with the delays
// and produces the next state together with the event flags of one sample.
// ----------------------------------------------------------------------------
module bcg_fsm
  import bcg_pkg::*;
(
  input  gesture_state_t cur_state,
  input  logic [31:0]    last_time,
  input  logic           pressed,
  input  logic [31:0]    time_us,
  input  delays_t        delays,
  output step_t          step
);

  logic [31:0]    elapsed;
  logic           deb_hit;
  logic           long_hit;
  logic           single_hit;
  gesture_state_t nxt;

  // Elapsed time is signed; a negative value reaches no delay.
  assign elapsed    = time_us - last_time;
  assign deb_hit    = !elapsed[31] && (elapsed[30:0] >= {7'd0, delays.settle_delay});
  assign long_hit   = !elapsed[31] && (elapsed[30:0] >= {7'd0, delays.long_click_delay});
  assign single_hit = !elapsed[31] && (elapsed[30:0] >= {7'd0, delays.single_click_delay});

  always_comb begin
    unique case (cur_state)
      ST_IDLE:         nxt = pressed ? ST_DEBOUNCE : ST_IDLE;
      ST_DEBOUNCE:     nxt = !pressed ? ST_IDLE : (deb_hit ? ST_PRESSED : ST_DEBOUNCE);
      ST_PRESSED:      nxt = !pressed ? ST_CLICK_UP : (long_hit ? ST_LONG : ST_PRESSED);
      ST_CLICK_UP:     nxt = ST_CLICK_IDLE;
      ST_CLICK_IDLE:   nxt = pressed ? ST_DBL_DEBOUNCE
                                     : (single_hit ? ST_SINGLE : ST_CLICK_IDLE);
      ST_SINGLE:       nxt = ST_IDLE;
      ST_DBL_DEBOUNCE: nxt = !pressed ? ST_CLICK_IDLE
                                      : (deb_hit ? ST_DOUBLE : ST_DBL_DEBOUNCE);
      ST_DOUBLE:       nxt = pressed ? ST_DOUBLE : ST_OTHER_UP;
      ST_LONG:         nxt = pressed ? ST_LONG : ST_OTHER_UP;
      ST_OTHER_UP:     nxt = ST_IDLE;
      default:         nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    step.state        = nxt;
    step.changed      = (nxt != cur_state);
    step.click        = step.changed && (nxt == ST_PRESSED || nxt == ST_DOUBLE);
    step.single_click = step.changed && (nxt == ST_SINGLE);
    step.double_click = step.changed && (nxt == ST_DOUBLE);
    step.long_click   = step.changed && (nxt == ST_LONG);
    step.released     = step.changed && (nxt == ST_CLICK_UP || nxt == ST_OTHER_UP);
  end

endmodule

// ----- test/tb_button_click_gesture_detector.sv -----
// ----------------------------------------------------------------------------
// tb_button_click_gesture_detector: self-checking bench for the gesture detector
// Drives button samples with timestamps through the input handshake and checks
// every result beat against a cycle-free model of the ten-state gesture
// machine. Directed gesture paths and time edge cases come first. Random
// gestures follow under several delay settings, with random stalls on both
// sides and two long held-off stretches of the output.
// ----------------------------------------------------------------------------
module tb_button_click_gesture_detector;
  import bcg_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int TIMEOUT_CYCLES = 400000;
  // The block has three registers, so index three must be ignored.
  localparam logic [1:0] REG_UNUSED_INDEX = 2'd3;

  // One expected result beat, field for field as on the result port.
  typedef struct packed {
    logic [3:0] gesture_state;
    logic       changed;
    logic       click;
    logic       single_click;
    logic       double_click;
    logic       long_click;
    logic       released;
  } gesture_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_pressed = 1'b0;
  logic [31:0] in_time_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_gesture_state;
  logic        out_changed;
  logic        out_click;
  logic        out_single_click;
  logic        out_double_click;
  logic        out_long_click;
  logic        out_released;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;

  // Model of the gesture machine: its state, the time of its last state
  // change and the three delays as they stand in the block.
  logic [3:0]  fsm_code = CODE_IDLE;
  logic [31:0] fsm_mark_us = '0;
  logic [23:0] delay_us [0:2] = '{SETTLE_DELAY_RST, LONG_CLICK_DELAY_RST,
                                  SINGLE_CLICK_DELAY_RST};

  // Results still owed by the block, oldest first.
  gesture_beat_t gesture_beats_due [$];

  int unsigned mismatch_count = 0;
  // Samples that the machine does not simply ignore; they pace the random part.
  int unsigned busy_samples = 0;
  // Percent of cycles in which the sender and the receiver idle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // A nonzero value asks the receiver to hold off for that many cycles.
  int unsigned stall_request = 0;
  // Running timestamp of the random stimulus and its largest step.
  logic [31:0] clock_us = '0;
  int unsigned tick_max = 1;

  button_click_gesture_detector u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pressed        (in_pressed),
    .in_time_us        (in_time_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_gesture_state (out_gesture_state),
    .out_changed       (out_changed),
    .out_click         (out_click),
    .out_single_click  (out_single_click),
    .out_double_click  (out_double_click),
    .out_long_click    (out_long_click),
    .out_released      (out_released),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The elapsed time is a signed 32-bit quantity. A negative value, which
  // shows as a set top bit, never reaches any delay, however small.
  function automatic logic held_long_enough(input logic [31:0] since,
                                            input logic [23:0] delay);
    return !since[31] && since >= {8'd0, delay};
  endfunction

  // Advances the gesture model by one sample and returns the beat it causes.
  function automatic gesture_beat_t step_gesture_fsm(input logic level,
                                                     input logic [31:0] now_us);
    logic [31:0]   since;
    logic [3:0]    next_code;
    gesture_beat_t beat;
    since = now_us - fsm_mark_us;
    case (fsm_code)
      CODE_IDLE: begin
        next_code = level ? CODE_DEBOUNCE : CODE_IDLE;
      end
      CODE_DEBOUNCE: begin
        if (!level) next_code = CODE_IDLE;
        else if (held_long_enough(since, delay_us[REG_SETTLE_DELAY])) begin
          next_code = CODE_PRESSED;
        end else next_code = CODE_DEBOUNCE;
      end
      CODE_PRESSED: begin
        if (!level) next_code = CODE_CLICK_UP;
        else if (held_long_enough(since, delay_us[REG_LONG_CLICK_DELAY])) begin
          next_code = CODE_LONG;
        end else next_code = CODE_PRESSED;
      end
      CODE_CLICK_UP: begin
        next_code = CODE_CLICK_IDLE;
      end
      CODE_CLICK_IDLE: begin
        if (level) next_code = CODE_DBL_DEBOUNCE;
        else if (held_long_enough(since, delay_us[REG_SINGLE_CLICK_DELAY])) begin
          next_code = CODE_SINGLE;
        end else next_code = CODE_CLICK_IDLE;
      end
      CODE_DBL_DEBOUNCE: begin
        if (!level) next_code = CODE_CLICK_IDLE;
        else if (held_long_enough(since, delay_us[REG_SETTLE_DELAY])) begin
          next_code = CODE_DOUBLE;
        end else next_code = CODE_DBL_DEBOUNCE;
      end
      CODE_DOUBLE: begin
        next_code = level ? CODE_DOUBLE : CODE_OTHER_UP;
      end
      CODE_LONG: begin
        next_code = level ? CODE_LONG : CODE_OTHER_UP;
      end
      // Single click and other-up fall back to idle whatever the button does.
      default: begin
        next_code = CODE_IDLE;
      end
    endcase
    beat.changed = next_code != fsm_code;
    if (beat.changed) begin
      fsm_code = next_code;
      fsm_mark_us = now_us;
    end
    beat.gesture_state = fsm_code;
    beat.click = beat.changed && (fsm_code == CODE_PRESSED || fsm_code == CODE_DOUBLE);
    beat.single_click = beat.changed && fsm_code == CODE_SINGLE;
    beat.double_click = beat.changed && fsm_code == CODE_DOUBLE;
    beat.long_click = beat.changed && fsm_code == CODE_LONG;
    beat.released = beat.changed &&
                    (fsm_code == CODE_CLICK_UP || fsm_code == CODE_OTHER_UP);
    return beat;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    mismatch_count++;
  endtask

  // Sends one sample. Valid stays high from one beat to the next unless the
  // sender decides to idle; the expectation is recorded at the accepting edge.
  task automatic send_sample(input logic level, input logic [31:0] stamp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_pressed <= level;
    in_time_us <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (level || fsm_code != CODE_IDLE) busy_samples++;
    gesture_beats_due.push_back(step_gesture_fsm(level, stamp));
  endtask

  // Stops offering samples and waits until every owed result has come.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (gesture_beats_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after its last write.
  task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    if (index != REG_UNUSED_INDEX) delay_us[index] = value;
  endtask

  // Reprograms all three delays while the block is idle. A write to the
  // unused index with random data follows and must change nothing.
  task automatic program_delays(input logic [23:0] debounce, input logic [23:0] long_hold,
                                input logic [23:0] single_gap);
    drain_results();
    write_reg(REG_SETTLE_DELAY, debounce);
    write_reg(REG_LONG_CLICK_DELAY, long_hold);
    write_reg(REG_SINGLE_CLICK_DELAY, single_gap);
    write_reg(REG_UNUSED_INDEX, 24'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Holds one button level for at least the given span, in random steps.
  task automatic hold_level(input logic level, input logic [31:0] span);
    logic [31:0] waited;
    logic [31:0] step;
    waited = '0;
    do begin
      step = $urandom_range(tick_max, 1);
      clock_us += step;
      waited += step;
      send_sample(level, clock_us);
    end while (waited < span);
  endtask

  // One random gesture. Most are well formed with random timing around the
  // programmed delays; the rest are bounces, broken double clicks and noise
  // with jumps of the timestamp, backward ones included.
  task automatic play_gesture();
    logic [31:0] deb;
    logic [31:0] lng;
    logic [31:0] sgl;
    deb = 32'(delay_us[REG_SETTLE_DELAY]);
    lng = 32'(delay_us[REG_LONG_CLICK_DELAY]);
    sgl = 32'(delay_us[REG_SINGLE_CLICK_DELAY]);
    case ($urandom_range(9))
      0, 1, 2: begin
        hold_level(1'b1, deb + $urandom_range(lng / 2));
        hold_level(1'b0, sgl + $urandom_range(tick_max));
      end
      3, 4: begin
        hold_level(1'b1, deb + $urandom_range(lng / 2));
        hold_level(1'b0, $urandom_range(sgl));
        hold_level(1'b1, deb + $urandom_range(tick_max * 2));
        hold_level(1'b0, sgl + $urandom_range(tick_max));
      end
      5, 6: begin
        hold_level(1'b1, deb + lng + $urandom_range(tick_max * 2));
        hold_level(1'b0, $urandom_range(sgl));
      end
      7: begin
        hold_level(1'b1, $urandom_range(deb));
        hold_level(1'b0, $urandom_range(tick_max));
      end
      8: begin
        hold_level(1'b1, deb + $urandom_range(tick_max));
        hold_level(1'b0, $urandom_range(sgl));
        hold_level(1'b1, $urandom_range(deb));
        hold_level(1'b0, sgl + $urandom_range(tick_max));
      end
      default: begin
        repeat ($urandom_range(4, 1)) begin
          case ($urandom_range(2))
            0: clock_us = $urandom;
            1: clock_us -= $urandom_range(tick_max * 4, 1);
            default: clock_us += 32'h8000_0000 + $urandom_range(tick_max);
          endcase
          send_sample(1'($urandom_range(1)), clock_us);
        end
      end
    endcase
  endtask

  // Plays random gestures until the given number of samples that the machine
  // does not ignore have gone in. Steps scale with the largest delay.
  task automatic play_random_gestures(input int unsigned count);
    int unsigned goal;
    int unsigned widest;
    widest = 32'(delay_us[REG_SETTLE_DELAY]);
    if (delay_us[REG_LONG_CLICK_DELAY] > widest) begin
      widest = 32'(delay_us[REG_LONG_CLICK_DELAY]);
    end
    if (delay_us[REG_SINGLE_CLICK_DELAY] > widest) begin
      widest = 32'(delay_us[REG_SINGLE_CLICK_DELAY]);
    end
    tick_max = widest / 8 + 1;
    goal = busy_samples + count;
    while (busy_samples < goal) play_gesture();
  endtask

  // Walks the click, double click, long click and single click paths at the
  // reset delays, with samples one microsecond short of each delay and exactly
  // on it. The first samples also cross the wrap of the timestamp.
  task automatic test_gesture_paths();
    logic [31:0] t;
    // Idle with the button up ignores the sample and records no time.
    send_sample(1'b0, 32'hFFFF_FFFF);
    t = 32'hFFFF_F000;
    send_sample(1'b1, t);
    send_sample(1'b1, t + SETTLE_DELAY_RST - 32'd1);
    t += SETTLE_DELAY_RST;
    send_sample(1'b1, t);
    // Released before the long delay: a click that may become a double.
    t += 32'd10;
    send_sample(1'b0, t);
    t += 32'd1;
    send_sample(1'b0, t);
    t += 32'd1;
    send_sample(1'b1, t);
    // A bounce in the second press goes back to waiting for the click.
    t += 32'd1;
    send_sample(1'b0, t);
    t += 32'd1;
    send_sample(1'b1, t);
    send_sample(1'b1, t + SETTLE_DELAY_RST - 32'd1);
    t += SETTLE_DELAY_RST;
    send_sample(1'b1, t);
    t += 32'd5;
    send_sample(1'b0, t);
    t += 32'd1;
    send_sample(1'b0, t);
    // Long click: held past the long delay, then released.
    t += 32'd1;
    send_sample(1'b1, t);
    t += SETTLE_DELAY_RST;
    send_sample(1'b1, t);
    send_sample(1'b1, t + LONG_CLICK_DELAY_RST - 32'd1);
    t += LONG_CLICK_DELAY_RST;
    send_sample(1'b1, t);
    t += 32'd9;
    send_sample(1'b0, t);
    // Other-up returns to idle even with the button down again.
    t += 32'd1;
    send_sample(1'b1, t);
    // Single click: the release outlasts the single click delay.
    t += 32'd1;
    send_sample(1'b1, t);
    t += SETTLE_DELAY_RST;
    send_sample(1'b1, t);
    t += 32'd3;
    send_sample(1'b0, t);
    t += 32'd1;
    send_sample(1'b0, t);
    send_sample(1'b0, t + SINGLE_CLICK_DELAY_RST - 32'd1);
    t += SINGLE_CLICK_DELAY_RST;
    send_sample(1'b0, t);
    // The single click also falls back to idle with the button down.
    send_sample(1'b1, t + 32'd1);
  endtask

  // Negative elapsed times, one microsecond back and half the range away,
  // must not satisfy the debounce delay; the largest positive one does.
  task automatic test_time_edges();
    logic [31:0] t;
    t = 32'h1234_5678;
    send_sample(1'b1, t);
    send_sample(1'b1, t - 32'd1);
    send_sample(1'b1, t + 32'h8000_0000);
    send_sample(1'b0, t + 32'd2);
    t += 32'd3;
    send_sample(1'b1, t);
    send_sample(1'b1, t + 32'h7FFF_FFFF);
  endtask

  task automatic test_default_delays();
    clock_us = $urandom;
    play_random_gestures(300);
  endtask

  task automatic test_short_delays();
    program_delays(24'($urandom_range(40)), 24'($urandom_range(400, 60)),
                   24'($urandom_range(200, 20)));
    play_random_gestures(350);
  endtask

  // With zero delays every timed step is taken on its first sample whose time stamp is not behind the last change.
  task automatic test_zero_delays();
    program_delays('0, '0, '0);
    play_random_gestures(250);
  endtask

  task automatic test_max_delays();
    program_delays('1, '1, '1);
    play_random_gestures(250);
  endtask

  task automatic test_random_delays();
    program_delays(24'($urandom), 24'($urandom), 24'($urandom));
    play_random_gestures(250);
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so
  // the block fills and stops taking input. After that the sender waits for
  // every result before a second, shorter hold-off.
  task automatic test_output_stall();
    program_delays(24'($urandom_range(40)), 24'($urandom_range(400, 60)),
                   24'($urandom_range(200, 20)));
    stall_request = 300;
    play_random_gestures(100);
    drain_results();
    stall_request = 200;
    play_random_gestures(50);
  endtask

  // Receiver: a random ready, or a held-off stretch when one is asked for.
  initial begin : drive_out_ready
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  // Every accepted result beat is matched against the oldest expectation.
  always @(posedge clk) begin : check_beats
    gesture_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (gesture_beats_due.size() == 0) begin
        flag_mismatch("result beat with none expected, gesture_state", 0,
                      32'(out_gesture_state));
      end else begin
        want = gesture_beats_due.pop_front();
        if (out_gesture_state !== want.gesture_state) begin
          flag_mismatch("gesture_state", 32'(want.gesture_state),
                        32'(out_gesture_state));
        end
        if (out_changed !== want.changed) begin
          flag_mismatch("changed", 32'(want.changed), 32'(out_changed));
        end
        if (out_click !== want.click) begin
          flag_mismatch("click", 32'(want.click), 32'(out_click));
        end
        if (out_single_click !== want.single_click) begin
          flag_mismatch("single_click", 32'(want.single_click), 32'(out_single_click));
        end
        if (out_double_click !== want.double_click) begin
          flag_mismatch("double_click", 32'(want.double_click), 32'(out_double_click));
        end
        if (out_long_click !== want.long_click) begin
          flag_mismatch("long_click", 32'(want.long_click), 32'(out_long_click));
        end
        if (out_released !== want.released) begin
          flag_mismatch("released", 32'(want.released), 32'(out_released));
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    // First the sender idles less than the receiver.
    send_idle_pct = 30;
    recv_idle_pct = 46;
    test_gesture_paths();
    test_time_edges();
    test_default_delays();
    test_short_delays();
    // Then the other way round.
    send_idle_pct = 46;
    recv_idle_pct = 30;
    test_zero_delays();
    test_max_delays();
    test_random_delays();
    // Then neither side idles on its own.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    test_random_delays();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bcg_pkg.sv
rtl/bcg_cfg.sv
rtl/bcg_fsm.sv
rtl/button_click_gesture_detector.sv
test/tb_button_click_gesture_detector.sv
